FILE: sv/gfm_pkg.sv
// Shared types, constants and the multiply-by-x helper for the GF(2^128) multiplier.
// No dependencies; imported by gfm_cell and gf128_field_multiply.
`default_nettype none

package gfm_pkg;

    localparam int BLK_W     = 128;
    localparam int HALF_W    = 64;
    localparam int CELL_BITS = 8;
    localparam int NUM_CELLS = BLK_W / CELL_BITS;

    // x^128 = x^7 + x^2 + x + 1
    localparam logic [BLK_W-1:0] FOLD_POLY = BLK_W'('h87);

    typedef logic [BLK_W-1:0] blk_t;

    // Operand set that moves from cell to cell
    typedef struct packed {
        blk_t a;    // first operand, multiplied by x once per consumed bit
        blk_t b;    // second operand, unconsumed bits at the bottom
        blk_t acc;  // partial product
    } gfm_word_t;

    function automatic blk_t gfm_xtime(input blk_t v);
        blk_t r;
        r = {v[BLK_W-2:0], 1'b0};
        if (v[BLK_W-1]) begin
            r = r ^ FOLD_POLY;
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: sv/gfm_cell.sv
// One cell of the multiplier chain: consumes CELL_BITS bits of the second operand.
// Depends on gfm_pkg.
`default_nettype none

module gfm_cell (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire gfm_pkg::gfm_word_t in_word,
    output logic                  out_valid,
    input  wire logic             out_ready,
    output gfm_pkg::gfm_word_t    out_word
);
    import gfm_pkg::*;

    logic      valid_reg;
    logic      valid_next;
    gfm_word_t word_reg;
    gfm_word_t word_next;
    logic      load;

    // a bubble here lets the upstream cell move even while downstream stalls
    assign in_ready = !valid_reg || out_ready;
    assign load     = in_valid && in_ready;

    always_comb begin
        blk_t a;
        blk_t acc;
        a   = in_word.a;
        acc = in_word.acc;
        for (int j = 0; j < CELL_BITS; j++) begin
            if (in_word.b[j]) begin
                acc = acc ^ a;
            end
            a = gfm_xtime(a);
        end
        word_next.a   = a;
        word_next.acc = acc;
        word_next.b   = in_word.b >> CELL_BITS;
    end

    always_comb begin
        valid_next = valid_reg;
        if (in_ready) begin
            valid_next = in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            word_reg <= word_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_word  = word_reg;

    // held item must not change or vanish while downstream stalls
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && !out_ready |=> valid_reg && $stable(word_reg))
        else $error("gfm_cell: stalled item changed");

    // an empty cell always takes from upstream
    a_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        !valid_reg |-> in_ready)
        else $error("gfm_cell: empty cell not ready");

    // a cell that was full and drained without refill goes empty
    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        valid_reg && out_ready && !in_valid |=> !valid_reg)
        else $error("gfm_cell: item repeated");

endmodule

`default_nettype wire

FILE: sv/gf128_field_multiply.sv
// Top level of the GF(2^128) multiplier: a chain of gfm_cell stages.
// Depends on gfm_pkg and gfm_cell.
`default_nettype none

// Multiplies two 128-bit values in GF(2^128) modulo x^128 + x^7 + x^2 + x + 1
// (non-reflected, bit k is the coefficient of x^k). Accepts one operand pair
// per clock and returns one product per clock when the output is not stalled.
// There are 16 cells in a row, each consuming 8 bits of the second
// operand. Each cell carries its own ready, so bubbles in the chain are
// squeezed out while the output is held and input keeps flowing until the
// chain is full. Results come out in input order.
module gf128_field_multiply (
    input  wire logic         aclk,
    input  wire logic         aresetn,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // a_low [63:0], a_high [127:64], b_low [191:128], b_high [255:192]
    input  wire logic [255:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // product_low [63:0], product_high [127:64]
    output logic [127:0]      m_tdata
);
    import gfm_pkg::*;

    logic      valid [NUM_CELLS+1];
    logic      ready [NUM_CELLS+1];
    gfm_word_t word  [NUM_CELLS+1];

    assign valid[0]     = s_tvalid;
    assign s_tready     = ready[0];
    assign word[0].a    = s_tdata[2*HALF_W-1:0];
    assign word[0].b    = s_tdata[4*HALF_W-1:2*HALF_W];
    assign word[0].acc  = '0;

    for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
        gfm_cell u_cell (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .in_valid  (valid[i]),
            .in_ready  (ready[i]),
            .in_word   (word[i]),
            .out_valid (valid[i+1]),
            .out_ready (ready[i+1]),
            .out_word  (word[i+1])
        );
    end

    assign m_tvalid         = valid[NUM_CELLS];
    assign ready[NUM_CELLS] = m_tready;
    assign m_tdata          = word[NUM_CELLS].acc;

endmodule

`default_nettype wire
